### sv/mtf_kv_pkg.sv
`default_nettype none

package mtf_kv_pkg;

	// Operation codes carried in the mode field
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// Fixed field widths of the request and response words
	localparam int unsigned KEY_W   = 16;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef struct packed {
		logic [1:0]         mode;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [VALUE_W-1:0] data_out;
		logic               rejected_full;
		logic               is_empty;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic do_insert;
		logic do_lookup;
		logic do_remove;
		logic finish;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [1:0] mode;
		logic       hit;
	} ctl_stat_t;

endpackage

`default_nettype wire

### sv/mtf_kv_ctrl.sv
`default_nettype none

module mtf_kv_ctrl
	import mtf_kv_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	output logic           done,
	output ctl_cmd_t       cmd,
	input  wire ctl_stat_t stat
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q, state_d;
	logic done_q, done_d;

	// Sequence one word: latch, then execute until the operation settles
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (stat.mode)
					MODE_INSERT: begin
						cmd.do_insert = 1'b1;
						cmd.finish    = 1'b1;
					end
					MODE_LOOKUP: begin
						cmd.do_lookup = 1'b1;
						cmd.finish    = 1'b1;
					end
					MODE_REMOVE: begin
						// delete one match per cycle until none is left
						if (stat.hit) begin
							cmd.do_remove = 1'b1;
						end else begin
							cmd.finish = 1'b1;
						end
					end
					default: begin
						cmd.finish = 1'b1;
					end
				endcase
				if (cmd.finish) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	// An accepted word always moves the controller into execution
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// A result strobe follows only a cycle of execution
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("result strobe without execution");

	// The strobe lasts one cycle per word
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");
`endif

endmodule

`default_nettype wire

### sv/mtf_kv_dp.sv
`default_nettype none

module mtf_kv_dp
	import mtf_kv_pkg::*;
#(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned KEY_BITS   = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire req_t     req,
	input  wire ctl_cmd_t cmd,
	output ctl_stat_t     stat,
	output rsp_t          result
);

	// Stored widths: field bits above them are ignored on load and returned as zero
	localparam int unsigned KSW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int unsigned VSW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int unsigned OW  = $clog2(CAPACITY + 1);

	logic [1:0]     op_mode_q;
	logic [KSW-1:0] op_key_q;
	logic [VSW-1:0] op_val_q;

	logic [KSW-1:0] key_q [CAPACITY];
	logic [VSW-1:0] val_q [CAPACITY];
	logic [KSW-1:0] key_dn [CAPACITY];
	logic [VSW-1:0] val_dn [CAPACITY];
	logic [KSW-1:0] key_up [CAPACITY];
	logic [VSW-1:0] val_up [CAPACITY];

	logic [OW-1:0]       occ_q, occ_nxt;
	logic                rm_hit_q;
	logic [CAPACITY-1:0] match, ahead, first;
	logic                hit, full;
	logic [VSW-1:0]      hit_val;
	rsp_t                res_q;
	logic [31:0]         occ_ext;

	// Latch the operation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_mode_q <= req.mode;
			op_key_q  <= req.key[KSW-1:0];
			op_val_q  <= req.value[VSW-1:0];
		end
	end

	// Compare the key in every held cell, then keep only the frontmost match
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cmp
			assign match[gi] = (occ_q > OW'(gi)) && (key_q[gi] == op_key_q);
		end
	endgenerate

	always_comb begin
		ahead[0] = 1'b0;
		for (int i = 1; i < CAPACITY; i++) begin
			ahead[i] = ahead[i-1] | match[i-1];
		end
		first = match & ~ahead;
		hit   = ahead[CAPACITY-1] | match[CAPACITY-1];
	end

	always_comb begin
		hit_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_val = hit_val | (val_q[i] & {VSW{first[i]}});
		end
	end

	assign full = (occ_q == OW'(CAPACITY));

	// Neighbor sources for shifting back (insert, move) and forward (delete)
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_nbr
			if (gi == 0) begin : g_head
				assign key_dn[gi] = op_key_q;
				assign val_dn[gi] = cmd.do_lookup ? hit_val : op_val_q;
			end else begin : g_body
				assign key_dn[gi] = key_q[gi-1];
				assign val_dn[gi] = val_q[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_tail
				assign key_up[gi] = key_q[gi];
				assign val_up[gi] = val_q[gi];
			end else begin : g_mid
				assign key_up[gi] = key_q[gi+1];
				assign val_up[gi] = val_q[gi+1];
			end
		end
	endgenerate

	// Update each cell from its neighbors
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			always_ff @(posedge clk) begin
				if (cmd.do_insert && !full) begin
					key_q[gi] <= key_dn[gi];
					val_q[gi] <= val_dn[gi];
				end else if (cmd.do_lookup && hit && !ahead[gi]) begin
					key_q[gi] <= key_dn[gi];
					val_q[gi] <= val_dn[gi];
				end else if (cmd.do_remove && (ahead[gi] || match[gi])) begin
					key_q[gi] <= key_up[gi];
					val_q[gi] <= val_up[gi];
				end
			end
		end
	endgenerate

	// Track occupancy
	always_comb begin
		occ_nxt = occ_q;
		if (cmd.do_insert && !full) begin
			occ_nxt = occ_q + OW'(1);
		end else if (cmd.do_remove && hit) begin
			occ_nxt = occ_q - OW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			rm_hit_q <= 1'b0;
		end else begin
			occ_q <= occ_nxt;
			if (cmd.load) begin
				rm_hit_q <= 1'b0;
			end else if (cmd.do_remove) begin
				rm_hit_q <= 1'b1;
			end
		end
	end

	assign occ_ext = 32'(occ_nxt);

	// Capture the result word when the operation settles
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.found         <= ((op_mode_q == MODE_LOOKUP) && hit)
			                       || ((op_mode_q == MODE_REMOVE) && rm_hit_q);
			res_q.data_out      <= ((op_mode_q == MODE_LOOKUP) && hit)
			                       ? VALUE_W'(hit_val) : '0;
			res_q.rejected_full <= (op_mode_q == MODE_INSERT) && full;
			res_q.is_empty      <= (occ_nxt == '0);
			res_q.entry_count   <= occ_ext[COUNT_W-1:0];
		end
	end

	assign stat.mode = op_mode_q;
	assign stat.hit  = hit;
	assign result    = res_q;

`ifndef SYNTHESIS
	// Occupancy never passes the number of cells
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(CAPACITY))
		else $error("occupancy beyond capacity");

	// A delete step always removes exactly one held entry
	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_remove |=> occ_q == $past(occ_q) - OW'(1))
		else $error("delete step did not drop one entry");

	// At most one frontmost match
	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first))
		else $error("more than one frontmost match");
`endif

endmodule

`default_nettype wire

### sv/move_to_front_key_value_table_unit.sv
`default_nettype none

// Move-to-front key/value table of CAPACITY cells, front first. A word is taken
// when start is high and busy is low; its result appears on result for exactly
// one cycle with done high, and the receiver must take it then, as it cannot
// hold results off. Insert and lookup latch the word, then compare and shift the
// cell row, with done in the first cycle that busy is low again, so a new word
// may be started in the same cycle that done is shown. Remove latches the word,
// then the cell row drops one match per cycle until none is left. Cell contents
// need no clearing after reset: only cells below the entry count are ever
// compared or read.
module move_to_front_key_value_table_unit
	import mtf_kv_pkg::*;
#(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned KEY_BITS   = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      result
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// Sequence operations
	mtf_kv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Hold and reorder the entries
	mtf_kv_dp #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top
	import mtf_kv_pkg::*;
();

	localparam int unsigned TABLE_DEPTH = 16;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;
	localparam int unsigned HOT_KEYS    = 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t result;

	move_to_front_key_value_table_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	// Free-running clock, period 10
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the table, front entry at index 0
	logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
	logic [VALUE_W-1:0] shadow_vals [TABLE_DEPTH];
	int unsigned        shadow_held = 0;

	rsp_t        pending_responses[$];
	logic [KEY_W-1:0] hot_keys [HOT_KEYS];
	bit          idle_enabled = 1'b1;
	int unsigned mismatch_count = 0;
	int unsigned words_sent = 0;
	int unsigned inserts_done = 0, inserts_rejected = 0;
	int unsigned lookup_hits = 0, lookup_misses = 0;
	int unsigned entries_removed = 0, removes_empty = 0, unused_words = 0;
	int unsigned peak_held = 0;

	// Apply one word to the shadow table and return the response it should produce
	function automatic rsp_t table_outcome(input req_t word);
		rsp_t             rsp;
		int               hit_pos;
		int unsigned      kept;
		logic [VALUE_W-1:0] hit_val;
		rsp     = '0;
		hit_pos = -1;
		kept    = 0;
		case (word.mode)
			MODE_INSERT: begin
				if (shadow_held >= TABLE_DEPTH) begin
					rsp.rejected_full = 1'b1;
					inserts_rejected++;
				end else begin
					for (int i = int'(shadow_held); i > 0; i--) begin
						shadow_keys[i] = shadow_keys[i-1];
						shadow_vals[i] = shadow_vals[i-1];
					end
					shadow_keys[0] = word.key;
					shadow_vals[0] = word.value;
					shadow_held++;
					inserts_done++;
				end
			end
			MODE_LOOKUP: begin
				for (int i = 0; i < int'(shadow_held); i++) begin
					if (hit_pos < 0 && shadow_keys[i] == word.key)
						hit_pos = i;
				end
				if (hit_pos >= 0) begin
					hit_val = shadow_vals[hit_pos];
					for (int i = hit_pos; i > 0; i--) begin
						shadow_keys[i] = shadow_keys[i-1];
						shadow_vals[i] = shadow_vals[i-1];
					end
					shadow_keys[0] = word.key;
					shadow_vals[0] = hit_val;
					rsp.found      = 1'b1;
					rsp.data_out   = hit_val;
					lookup_hits++;
				end else begin
					lookup_misses++;
				end
			end
			MODE_REMOVE: begin
				// compact in place, keeping order of survivors
				for (int i = 0; i < int'(shadow_held); i++) begin
					if (shadow_keys[i] != word.key) begin
						shadow_keys[kept] = shadow_keys[i];
						shadow_vals[kept] = shadow_vals[i];
						kept++;
					end
				end
				if (kept != shadow_held) begin
					rsp.found = 1'b1;
					entries_removed += shadow_held - kept;
					shadow_held = kept;
				end else begin
					removes_empty++;
				end
			end
			default: unused_words++;
		endcase
		rsp.is_empty    = (shadow_held == 0);
		rsp.entry_count = shadow_held[COUNT_W-1:0];
		if (shadow_held > peak_held)
			peak_held = shadow_held;
		return rsp;
	endfunction

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Present one word, hold it until taken, then record its expected response
	task automatic send_word(input req_t word);
		if (idle_enabled && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= word;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_responses.push_back(table_outcome(word));
		words_sent++;
	endtask

	function automatic req_t make_word(input logic [1:0] mode, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] value);
		req_t word;
		word.mode  = mode;
		word.key   = key;
		word.value = value;
		return word;
	endfunction

	// Compare each response against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("unexpected response", result.data_out, '0);
			end else begin
				want = pending_responses.pop_front();
				if (result.found !== want.found)
					report_mismatch("found", VALUE_W'(result.found),
						VALUE_W'(want.found));
				if (result.data_out !== want.data_out)
					report_mismatch("data_out", result.data_out, want.data_out);
				if (result.rejected_full !== want.rejected_full)
					report_mismatch("rejected_full", VALUE_W'(result.rejected_full),
						VALUE_W'(want.rejected_full));
				if (result.is_empty !== want.is_empty)
					report_mismatch("is_empty", VALUE_W'(result.is_empty),
						VALUE_W'(want.is_empty));
				if (result.entry_count !== want.entry_count)
					report_mismatch("entry_count", VALUE_W'(result.entry_count),
						VALUE_W'(want.entry_count));
			end
		end
	end

	// Operations on an empty table: misses, no-op remove, unused mode
	task automatic test_empty_table();
		send_word(make_word(MODE_LOOKUP, 16'h0000, 32'hFFFF_FFFF));
		send_word(make_word(MODE_REMOVE, 16'hFFFF, 32'h0000_0000));
		send_word(make_word(MODE_UNUSED, 16'h1234, 32'hDEAD_BEEF));
	endtask

	// Extremes, duplicates, lookup move to front, multi-match remove
	task automatic test_basic_ops();
		send_word(make_word(MODE_INSERT, 16'h0000, 32'h0000_0000));
		send_word(make_word(MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
		send_word(make_word(MODE_INSERT, 16'hFFFF, 32'h5555_5555));
		send_word(make_word(MODE_LOOKUP, 16'h0000, 32'hAAAA_AAAA));
		send_word(make_word(MODE_LOOKUP, 16'hFFFF, 32'h0000_0000));
		send_word(make_word(MODE_LOOKUP, 16'h8001, 32'h0000_0000));
		send_word(make_word(MODE_REMOVE, 16'hFFFF, 32'hFFFF_FFFF));
		send_word(make_word(MODE_REMOVE, 16'h7FFE, 32'h0000_0000));
		send_word(make_word(MODE_UNUSED, 16'h0000, 32'h0000_0000));
	endtask

	// Fill to capacity, get rejected, then shuffle and drain duplicates
	task automatic test_full_table();
		logic [KEY_W-1:0] key;
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			key = (i % 4 == 0) ? 16'h5A5A : (16'hA500 + 16'(i));
			send_word(make_word(MODE_INSERT, key, {16'hC000 + 16'(i), 16'(~i)}));
		end
		send_word(make_word(MODE_INSERT, 16'h1111, 32'h2222_2222));
		send_word(make_word(MODE_LOOKUP, 16'hA501, 32'h0000_0000));
		send_word(make_word(MODE_REMOVE, 16'h5A5A, 32'h0000_0000));
	endtask

	// Random traffic with a given mix of insert, lookup and remove weights (percent)
	task automatic run_random(input int unsigned count, input int unsigned ins_w,
			input int unsigned look_w, input int unsigned rem_w, input bit allow_idle);
		int unsigned      pick;
		logic [1:0]       mode;
		logic [KEY_W-1:0] key;
		for (int n = 0; n < int'(count); n++) begin
			// toggle idling in stretches so some runs go back to back
			if (n % 40 == 0)
				idle_enabled = allow_idle && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < ins_w)
				mode = MODE_INSERT;
			else if (pick < ins_w + look_w)
				mode = MODE_LOOKUP;
			else if (pick < ins_w + look_w + rem_w)
				mode = MODE_REMOVE;
			else
				mode = MODE_UNUSED;
			pick = $urandom_range(0, 99);
			if (pick < 40 && shadow_held > 0)
				key = shadow_keys[$urandom_range(0, shadow_held - 1)];
			else if (pick < 85)
				key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
			else
				key = KEY_W'($urandom());
			send_word(make_word(mode, key, $urandom()));
		end
	endtask

	task automatic test_random_growth();
		run_random(120, 70, 20, 7, 1'b1);
	endtask

	task automatic test_random_lookup();
		run_random(150, 20, 70, 7, 1'b1);
	endtask

	task automatic test_random_remove();
		run_random(100, 30, 20, 47, 1'b1);
	endtask

	task automatic test_random_mixed();
		run_random(150, 40, 35, 22, 1'b1);
	endtask

	task automatic test_back_to_back();
		run_random(100, 40, 35, 22, 1'b0);
	endtask

	initial begin
		for (int i = 0; i < HOT_KEYS; i++)
			hot_keys[i] = KEY_W'($urandom());
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_basic_ops();
		test_full_table();
		test_random_growth();
		test_random_lookup();
		test_random_remove();
		test_random_mixed();
		test_back_to_back();

		// release the bus and wait out the last responses
		start <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d words: %0d inserts, %0d rejected full, %0d unused-mode words.",
			words_sent, inserts_done, inserts_rejected, unused_words);
		$display("Lookups %0d hit / %0d miss; %0d entries removed, %0d empty removes; peak %0d held.",
			lookup_hits, lookup_misses, entries_removed, removes_empty, peak_held);
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("tb_top failed");
		end
		$finish;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Timeout with %0d responses outstanding", pending_responses.size());
		$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
sv/mtf_kv_pkg.sv
sv/mtf_kv_ctrl.sv
sv/mtf_kv_dp.sv
sv/move_to_front_key_value_table_unit.sv
dv/tb_top.sv
